// File: src/bim_pkg.sv
// ---------------------------------------------------------------------------
// bim_pkg
// Shared types and constants for the binary image moments block.
// ---------------------------------------------------------------------------
`default_nettype none

package bim_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH      = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT     = 2'd1;
  localparam logic [1:0] CFG_OBJECT_THRESHOLD = 2'd2;

  localparam int DIM_W    = 11;
  localparam int PIX_W    = 8;
  localparam int AREA_W   = 21;
  localparam int CENT_W   = 10;
  localparam int MOM_W    = 41;
  localparam int INV_W    = 48;
  localparam int FRAC_W   = 16;

  localparam logic [DIM_W-1:0] WIDTH_RESET     = 11'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RESET    = 11'd1024;
  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd100;

  // classification carried with each queued pixel
  typedef struct packed {
    logic obj;
    logic last;
  } bim_tag_t;

  typedef enum logic [3:0] {
    FIN_IDLE,
    FIN_DIVX,
    FIN_DIVY,
    FIN_MULA,
    FIN_MULB,
    FIN_MULC,
    FIN_MULD,
    FIN_MULE,
    FIN_MULF,
    FIN_MULG,
    FIN_DIVQ,
    FIN_EMIT
  } bim_fin_state_t;

endpackage

`default_nettype wire

// File: src/binary_image_moments.sv
// pixels are taken one per cycle; the front stalls only when its queue fills
// a result is computed after the last pixel of a frame is taken, with s2 the
// second-moment sum width (41 at 1024x1024) setting the width of the bit-serial
// divider in the end-of-frame unit; an empty frame skips the divider and multiplier
// frames shorter than a finisher pass are throttled to one frame per finisher pass
// synchronous reset restores the configuration defaults and clears all sums
// ---------------------------------------------------------------------------
// binary_image_moments
// Area, centroid, central moments and spread invariant of a thresholded frame.
// ---------------------------------------------------------------------------
`default_nettype none

module binary_image_moments
  import bim_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIX_W-1:0]        pixel_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [AREA_W-1:0]       object_area,
  output logic [CENT_W-1:0]       centroid_x,
  output logic [CENT_W-1:0]       centroid_y,
  output logic [MOM_W-1:0]        central_xx,
  output logic [MOM_W-1:0]        central_yy,
  output logic signed [MOM_W-1:0] central_xy,
  output logic [INV_W-1:0]        spread_invariant,
  output logic                    empty_object
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int MW  = (XW > YW) ? XW : YW;
  localparam int CW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int S1W = CW + MW;
  localparam int S2W = CW + 2 * MW;
  localparam int QW  = $bits(bim_tag_t) + XW + YW;

  logic           push;
  logic           queue_full;
  bim_tag_t       push_tag;
  logic [XW-1:0]  push_x;
  logic [YW-1:0]  push_y;
  logic           pop;
  logic           avail;
  logic [QW-1:0]  pop_data;
  bim_tag_t       pop_tag;
  logic [XW-1:0]  pop_x;
  logic [YW-1:0]  pop_y;
  logic           start_valid;
  logic           start_ready;
  logic [CW-1:0]  sum_count;
  logic [S1W-1:0] sum_x;
  logic [S1W-1:0] sum_y;
  logic [S2W-1:0] sum_xx;
  logic [S2W-1:0] sum_yy;
  logic [S2W-1:0] sum_xy;

  bim_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_value (pixel_value),
    .push        (push),
    .queue_full  (queue_full),
    .push_tag    (push_tag),
    .push_x      (push_x),
    .push_y      (push_y)
  );

  bim_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_tag, push_x, push_y}),
    .full      (queue_full),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_data)
  );

  assign {pop_tag, pop_x, pop_y} = pop_data;

  bim_accum #(
    .XW  (XW),
    .YW  (YW),
    .CW  (CW),
    .S1W (S1W),
    .S2W (S2W)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .avail       (avail),
    .pop         (pop),
    .tag         (pop_tag),
    .x           (pop_x),
    .y           (pop_y),
    .start_valid (start_valid),
    .start_ready (start_ready),
    .sum_count   (sum_count),
    .sum_x       (sum_x),
    .sum_y       (sum_y),
    .sum_xx      (sum_xx),
    .sum_yy      (sum_yy),
    .sum_xy      (sum_xy)
  );

  bim_finish #(
    .MW  (MW),
    .CW  (CW),
    .S1W (S1W),
    .S2W (S2W)
  ) u_finish (
    .clk              (clk),
    .rst              (rst),
    .start_valid      (start_valid),
    .start_ready      (start_ready),
    .sum_count        (sum_count),
    .sum_x            (sum_x),
    .sum_y            (sum_y),
    .sum_xx           (sum_xx),
    .sum_yy           (sum_yy),
    .sum_xy           (sum_xy),
    .res_valid        (out_valid),
    .res_ready        (out_ready),
    .object_area      (object_area),
    .centroid_x       (centroid_x),
    .centroid_y       (centroid_y),
    .central_xx       (central_xx),
    .central_yy       (central_yy),
    .central_xy       (central_xy),
    .spread_invariant (spread_invariant),
    .empty_object     (empty_object)
  );

endmodule

`default_nettype wire

// File: src/bim_front.sv
// ---------------------------------------------------------------------------
// bim_front
// Holds the configuration, tracks the raster position and classifies pixels.
// ---------------------------------------------------------------------------
`default_nettype none

module bim_front
  import bim_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [DIM_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [PIX_W-1:0]              pixel_value,
  output logic                          push,
  input  logic                          queue_full,
  output bim_tag_t                      push_tag,
  output logic [$clog2(MAX_WIDTH)-1:0]  push_x,
  output logic [$clog2(MAX_HEIGHT)-1:0] push_y
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int EW = 14;

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [PIX_W-1:0] object_threshold;
  logic [XW-1:0]    column_count;
  logic [YW-1:0]    row_count;
  logic [EW-1:0]    w_eff;
  logic [EW-1:0]    h_eff;
  logic             line_end;
  logic             frame_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= WIDTH_RESET;
      frame_height     <= HEIGHT_RESET;
      object_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:      frame_width      <= cfg_data;
        CFG_FRAME_HEIGHT:     frame_height     <= cfg_data;
        CFG_OBJECT_THRESHOLD: object_threshold <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // zero means one, oversize saturates
  always_comb begin
    w_eff = EW'(frame_width);
    if (frame_width == '0) w_eff = EW'(1);
    else if (EW'(frame_width) > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
    h_eff = EW'(frame_height);
    if (frame_height == '0) h_eff = EW'(1);
    else if (EW'(frame_height) > EW'(MAX_HEIGHT)) h_eff = EW'(MAX_HEIGHT);
  end

  assign line_end  = (EW'(column_count) + EW'(1)) >= w_eff;
  assign frame_end = line_end && ((EW'(row_count) + EW'(1)) >= h_eff);

  assign in_ready      = !queue_full;
  assign push          = in_valid && in_ready;
  assign push_tag.obj  = pixel_value <= object_threshold;
  assign push_tag.last = frame_end;
  assign push_x        = column_count;
  assign push_y        = row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (push) begin
      if (line_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_count + YW'(1);
      end else begin
        column_count <= column_count + XW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/bim_queue.sv
// ---------------------------------------------------------------------------
// bim_queue
// Short first-in first-out queue between the front and the accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module bim_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         avail,
  output logic [W-1:0] pop_data
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full     = count == (AW+1)'(DEPTH);
  assign avail    = count != '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// File: src/bim_accum.sv
// ---------------------------------------------------------------------------
// bim_accum
// Accumulates the raw moments of one frame and hands them to the finisher.
// ---------------------------------------------------------------------------
`default_nettype none

module bim_accum
  import bim_pkg::*;
#(
  parameter int XW  = 10,
  parameter int YW  = 10,
  parameter int CW  = 21,
  parameter int S1W = 31,
  parameter int S2W = 41
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  output logic           pop,
  input  bim_tag_t       tag,
  input  logic [XW-1:0]  x,
  input  logic [YW-1:0]  y,
  output logic           start_valid,
  input  logic           start_ready,
  output logic [CW-1:0]  sum_count,
  output logic [S1W-1:0] sum_x,
  output logic [S1W-1:0] sum_y,
  output logic [S2W-1:0] sum_xx,
  output logic [S2W-1:0] sum_yy,
  output logic [S2W-1:0] sum_xy
);

  logic               done;
  logic [2*XW-1:0]    xx;
  logic [2*YW-1:0]    yy;
  logic [XW+YW-1:0]   xy;

  assign pop         = avail && !done;
  assign start_valid = done;

  // full-width products of the pixel position
  assign xx = (2*XW)'(x) * (2*XW)'(x);
  assign yy = (2*YW)'(y) * (2*YW)'(y);
  assign xy = (XW+YW)'(x) * (XW+YW)'(y);

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      sum_count <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      sum_xx    <= '0;
      sum_yy    <= '0;
      sum_xy    <= '0;
    end else if (done) begin
      if (start_ready) begin
        done      <= 1'b0;
        sum_count <= '0;
        sum_x     <= '0;
        sum_y     <= '0;
        sum_xx    <= '0;
        sum_yy    <= '0;
        sum_xy    <= '0;
      end
    end else if (pop) begin
      if (tag.obj) begin
        sum_count <= sum_count + CW'(1);
        sum_x     <= sum_x + S1W'(x);
        sum_y     <= sum_y + S1W'(y);
        sum_xx    <= sum_xx + S2W'(xx);
        sum_yy    <= sum_yy + S2W'(yy);
        sum_xy    <= sum_xy + S2W'(xy);
      end
      if (tag.last) done <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: src/bim_finish.sv
// ---------------------------------------------------------------------------
// bim_finish
// End-of-frame unit: centroid, central moments and spread invariant, using
// one bit-serial divider and one shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module bim_finish
  import bim_pkg::*;
#(
  parameter int MW  = 10,
  parameter int CW  = 21,
  parameter int S1W = 31,
  parameter int S2W = 41
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start_valid,
  output logic                     start_ready,
  input  logic [CW-1:0]            sum_count,
  input  logic [S1W-1:0]           sum_x,
  input  logic [S1W-1:0]           sum_y,
  input  logic [S2W-1:0]           sum_xx,
  input  logic [S2W-1:0]           sum_yy,
  input  logic [S2W-1:0]           sum_xy,
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic [AREA_W-1:0]        object_area,
  output logic [CENT_W-1:0]        centroid_x,
  output logic [CENT_W-1:0]        centroid_y,
  output logic [MOM_W-1:0]         central_xx,
  output logic [MOM_W-1:0]         central_yy,
  output logic signed [MOM_W-1:0]  central_xy,
  output logic [INV_W-1:0]         spread_invariant,
  output logic                     empty_object
);

  localparam int DW   = 2 * CW;
  localparam int PW   = (DW > S2W) ? DW : S2W;
  localparam int NW   = (S2W + 1 + FRAC_W > INV_W + 1) ? S2W + 1 + FRAC_W : INV_W + 1;
  localparam int CNTW = $clog2(NW);

  bim_fin_state_t state, state_next;

  logic [CW-1:0]    n;
  logic [S1W-1:0]   sx;
  logic [S1W-1:0]   sy;
  logic [S2W-1:0]   sxx;
  logic [S2W-1:0]   syy;
  logic [S2W-1:0]   sxy;
  logic             empty;
  logic [MW-1:0]    cx;
  logic [MW-1:0]    cy;
  logic [PW-1:0]    u;
  logic [PW-1:0]    v;
  logic [PW-1:0]    mxx;
  logic [PW-1:0]    myy;
  logic [PW-1:0]    mxy;
  logic [INV_W-1:0] spread;

  logic [NW-1:0]    dvd;
  logic [DW-1:0]    dsr;
  logic [DW-1:0]    rem;
  logic [CNTW-1:0]  cnt;
  logic [DW:0]      rem_s;
  logic             ge;
  logic [DW-1:0]    rem_n;
  logic [NW-1:0]    dvd_n;
  logic             div_last;

  logic [CW-1:0]    ma;
  logic [PW-1:0]    mb;
  logic [PW-1:0]    mp;
  logic [S2W:0]     num;

  // one restoring division step per cycle
  assign rem_s    = {rem, dvd[NW-1]};
  assign ge       = rem_s >= {1'b0, dsr};
  assign rem_n    = ge ? DW'(rem_s - {1'b0, dsr}) : rem_s[DW-1:0];
  assign dvd_n    = {dvd[NW-2:0], ge};
  assign div_last = cnt == CNTW'(NW - 1);

  assign num = {1'b0, mxx[S2W-1:0]} + {1'b0, myy[S2W-1:0]};

  // shared multiplier, modulo 2^PW
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      FIN_MULA: begin ma = CW'(cx); mb = PW'(n); end
      FIN_MULB: begin ma = CW'(cy); mb = PW'(n); end
      FIN_MULC: begin ma = CW'(cx); mb = u - (PW'(sx) << 1); end
      FIN_MULD: begin ma = CW'(cy); mb = v - (PW'(sy) << 1); end
      FIN_MULE: begin ma = CW'(cx); mb = v - PW'(sy); end
      FIN_MULF: begin ma = CW'(cy); mb = PW'(sx); end
      FIN_MULG: begin ma = n;       mb = PW'(n); end
      default: ;
    endcase
  end
  assign mp = PW'(PW'(ma) * mb);

  always_ff @(posedge clk) begin
    if (rst) state <= FIN_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    start_ready = 1'b0;
    unique case (state)
      FIN_IDLE: begin
        start_ready = 1'b1;
        if (start_valid) state_next = (sum_count == '0) ? FIN_EMIT : FIN_DIVX;
      end
      FIN_DIVX: if (div_last) state_next = FIN_DIVY;
      FIN_DIVY: if (div_last) state_next = FIN_MULA;
      FIN_MULA: state_next = FIN_MULB;
      FIN_MULB: state_next = FIN_MULC;
      FIN_MULC: state_next = FIN_MULD;
      FIN_MULD: state_next = FIN_MULE;
      FIN_MULE: state_next = FIN_MULF;
      FIN_MULF: state_next = FIN_MULG;
      FIN_MULG: state_next = FIN_DIVQ;
      FIN_DIVQ: if (div_last) state_next = FIN_EMIT;
      FIN_EMIT: if (!res_valid || res_ready) state_next = FIN_IDLE;
      default:  state_next = FIN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      FIN_IDLE: begin
        if (start_valid) begin
          n     <= sum_count;
          sx    <= sum_x;
          sy    <= sum_y;
          sxx   <= sum_xx;
          syy   <= sum_yy;
          sxy   <= sum_xy;
          empty <= sum_count == '0;
          dvd   <= NW'(sum_x);
          dsr   <= DW'(sum_count);
          rem   <= '0;
          cnt   <= '0;
        end
      end
      FIN_DIVX, FIN_DIVY, FIN_DIVQ: begin
        dvd <= dvd_n;
        rem <= rem_n;
        cnt <= cnt + CNTW'(1);
        if (div_last) begin
          rem <= '0;
          cnt <= '0;
          if (state == FIN_DIVX) begin
            cx  <= MW'(dvd_n);
            dvd <= NW'(sy);
          end
          if (state == FIN_DIVY) cy <= MW'(dvd_n);
          if (state == FIN_DIVQ) begin
            // integer part beyond 32 bits saturates
            spread <= (|dvd_n[NW-1:INV_W]) ? '1 : dvd_n[INV_W-1:0];
          end
        end
      end
      FIN_MULA: u   <= mp;
      FIN_MULB: v   <= mp;
      FIN_MULC: mxx <= PW'(sxx) + mp;
      FIN_MULD: myy <= PW'(syy) + mp;
      FIN_MULE: mxy <= PW'(sxy) + mp;
      FIN_MULF: mxy <= mxy - mp;
      FIN_MULG: begin
        dsr <= DW'(mp);
        dvd <= NW'(num) << FRAC_W;
        rem <= '0;
        cnt <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (state == FIN_EMIT && (!res_valid || res_ready)) res_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FIN_EMIT && (!res_valid || res_ready)) begin
      empty_object <= empty;
      if (empty) begin
        object_area      <= '0;
        centroid_x       <= '0;
        centroid_y       <= '0;
        central_xx       <= '0;
        central_yy       <= '0;
        central_xy       <= '0;
        spread_invariant <= '0;
      end else begin
        object_area      <= AREA_W'(n);
        centroid_x       <= CENT_W'(cx);
        centroid_y       <= CENT_W'(cy);
        central_xx       <= MOM_W'(mxx[S2W-1:0]);
        central_yy       <= MOM_W'(myy[S2W-1:0]);
        central_xy       <= MOM_W'(signed'(mxy[S2W-1:0]));
        spread_invariant <= spread;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/bim_checker.sv
// ---------------------------------------------------------------------------
// bim_checker
// Port-level checks on the result channel of the moments block.
// ---------------------------------------------------------------------------
`default_nettype none

module bim_checker
  import bim_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [AREA_W-1:0]       object_area,
  input logic [CENT_W-1:0]       centroid_x,
  input logic [CENT_W-1:0]       centroid_y,
  input logic [MOM_W-1:0]        central_xx,
  input logic [MOM_W-1:0]        central_yy,
  input logic signed [MOM_W-1:0] central_xy,
  input logic [INV_W-1:0]        spread_invariant,
  input logic                    empty_object
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(object_area) && $stable(spread_invariant))
    else $error("result item dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // an empty frame reports nothing but the flag
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_object |-> object_area == 0 && centroid_x == 0 &&
      centroid_y == 0 && spread_invariant == 0)
    else $error("empty frame with nonzero fields");

  a_area: assert property (@(posedge clk) disable iff (rst)
    out_valid && !empty_object |-> object_area != 0)
    else $error("object frame with zero area");

  // a single pixel sits exactly on its centroid
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !empty_object && object_area == 1 |->
      central_xx == 0 && central_yy == 0 && central_xy == 0)
    else $error("single pixel with nonzero central moments");

endmodule

bind binary_image_moments bim_checker u_bim_checker (.*);

`default_nettype wire
